// ----- rtl/mghw_pkg.sv -----
package mghw_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAX_FINE   = 1024;
    localparam int POS_W      = $clog2(MAX_FINE);
    localparam int SIZE_W     = 11;
    localparam int IDX_W      = 9;
    localparam int SUM_W      = SAMPLE_W + 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_FLD_W  = SAMPLE_W + 2 * IDX_W;
    localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FINE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY  = 1'b1;

    localparam logic [SIZE_W-1:0]          FINE_SIZE_RST = 11'd1021;
    localparam logic signed [SAMPLE_W-1:0] BOUNDARY_RST  = 16'sd16384;
    localparam logic [SIZE_W-1:0]          MIN_SIZE      = 11'd3;
    localparam logic [SIZE_W-1:0]          MAX_SIZE      = SIZE_W'(MAX_FINE);

    // position and emission flags of one fine sample
    typedef struct packed {
        logic [POS_W-1:0] col;
        logic             emit;
        logic             bnd;
        logic             last;
        logic [IDX_W-1:0] ci;
        logic [IDX_W-1:0] cj;
    } pos_info_t;

endpackage

// ----- rtl/mghw_position.sv -----
module mghw_position
    import mghw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SIZE_W-1:0] fine_size,
    input  logic              advance,
    output pos_info_t         info
);

    logic [POS_W-1:0]  col_reg, col_next;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [SIZE_W-1:0] n;
    logic [POS_W-1:0]  n_m1;
    logic [IDX_W-1:0]  m_m1;
    logic              col_wrap;
    logic [POS_W-1:0]  col_eff;
    logic [POS_W-1:0]  row_eff;
    logic [SIZE_W-1:0] row_tmp;
    logic [SIZE_W-1:0] col_inc;
    logic [SIZE_W-1:0] row_inc;
    logic              odd_r;
    logic              odd_c;

    always_comb
    begin
        priority if (fine_size < MIN_SIZE)
            n = MIN_SIZE;
        else if (fine_size > MAX_SIZE)
            n = MAX_SIZE;
        else
            n = fine_size;
    end

    assign n_m1 = POS_W'(n - SIZE_W'(1));
    assign m_m1 = n_m1[POS_W-1:1];

    // wrap a position left stale by a size change
    assign col_wrap = {1'b0, col_reg} >= n;
    assign col_eff  = col_wrap ? '0 : col_reg;
    assign row_tmp  = {1'b0, row_reg} + SIZE_W'(col_wrap);
    assign row_eff  = (row_tmp >= n) ? '0 : row_tmp[POS_W-1:0];

    assign odd_r = row_eff[0] || (row_eff == n_m1);
    assign odd_c = col_eff[0] || (col_eff == n_m1);

    always_comb
    begin
        info.col  = col_eff;
        info.emit = odd_r && odd_c;
        info.ci   = row_eff[POS_W-1:1];
        info.cj   = col_eff[POS_W-1:1];
        info.bnd  = (info.ci == '0) || (info.cj == '0) || (info.ci == m_m1) || (info.cj == m_m1);
        info.last = (row_eff == n_m1) && (col_eff == n_m1);
    end

    assign col_inc = {1'b0, col_eff} + SIZE_W'(1);
    assign row_inc = {1'b0, row_eff} + SIZE_W'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (col_inc >= n)
            begin
                col_next = '0;
                row_next = (row_inc >= n) ? '0 : row_inc[POS_W-1:0];
            end
            else
            begin
                col_next = col_inc[POS_W-1:0];
                row_next = row_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ----- rtl/mghw_line_buffers.sv -----
module mghw_line_buffers
    import mghw_pkg::*;
(
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [POS_W-1:0]           rd_addr,
    output logic signed [SAMPLE_W-1:0] mid,
    output logic signed [SAMPLE_W-1:0] up,
    input  logic                       wr_en,
    input  logic [POS_W-1:0]           wr_addr,
    input  logic signed [SAMPLE_W-1:0] wr_one_back,
    input  logic signed [SAMPLE_W-1:0] wr_two_back
);

    logic signed [SAMPLE_W-1:0] one_back_mem [MAX_FINE];
    logic signed [SAMPLE_W-1:0] two_back_mem [MAX_FINE];
    logic signed [SAMPLE_W-1:0] mid_reg;
    logic signed [SAMPLE_W-1:0] up_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            one_back_mem[wr_addr] <= wr_one_back;
            two_back_mem[wr_addr] <= wr_two_back;
        end
    end

    // hold read data while the stencil stage is stalled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mid_reg <= one_back_mem[rd_addr];
            up_reg  <= two_back_mem[rd_addr];
        end
    end

    assign mid = mid_reg;
    assign up  = up_reg;

endmodule

// ----- rtl/mghw_stencil.sv -----
module mghw_stencil
    import mghw_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  pos_info_t                  info,
    output logic                       ready,
    input  logic signed [SAMPLE_W-1:0] mid,
    input  logic signed [SAMPLE_W-1:0] up,
    input  logic signed [SAMPLE_W-1:0] boundary_value,
    output logic                       wr_en,
    output logic [POS_W-1:0]           wr_addr,
    output logic signed [SAMPLE_W-1:0] wr_one_back,
    output logic signed [SAMPLE_W-1:0] wr_two_back,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_value,
    output logic [IDX_W-1:0]           out_row,
    output logic [IDX_W-1:0]           out_col,
    output logic                       out_last
);

    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_x_reg;
    pos_info_t                  s1_info_reg;
    logic signed [SAMPLE_W-1:0] pt0_reg;
    logic signed [SAMPLE_W-1:0] pt1_reg;
    logic signed [SAMPLE_W-1:0] up_tap_reg;
    logic signed [SAMPLE_W-1:0] cur_tap_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_value_reg;
    logic [IDX_W-1:0]           out_row_reg;
    logic [IDX_W-1:0]           out_col_reg;
    logic                       out_last_reg;
    logic                       s1_adv;
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] value_next;

    assign s1_adv = s1_valid_reg && (!out_valid_reg || out_ready);
    assign ready  = !s1_valid_reg || s1_adv;

    assign sum = (SUM_W'(pt1_reg) <<< 2) + SUM_W'(up_tap_reg) + SUM_W'(cur_tap_reg)
               + SUM_W'(pt0_reg) + SUM_W'(mid);

    // drop three low bits: floor division by eight
    assign value_next = s1_info_reg.bnd ? boundary_value : sum[SUM_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg    <= sample;
            s1_info_reg <= info;
        end
    end

    // advance the stencil window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt0_reg     <= '0;
            pt1_reg     <= '0;
            up_tap_reg  <= '0;
            cur_tap_reg <= '0;
        end
        else if (s1_adv)
        begin
            pt0_reg     <= pt1_reg;
            pt1_reg     <= mid;
            up_tap_reg  <= up;
            cur_tap_reg <= s1_x_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_info_reg.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_info_reg.emit)
        begin
            out_value_reg <= value_next;
            out_row_reg   <= s1_info_reg.ci;
            out_col_reg   <= s1_info_reg.cj;
            out_last_reg  <= s1_info_reg.last;
        end
    end

    assign wr_en       = s1_adv;
    assign wr_addr     = s1_info_reg.col;
    assign wr_one_back = s1_x_reg;
    assign wr_two_back = mid;

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- rtl/multigrid_half_weight_restrict.sv -----
// Half-weighting restriction of a streamed N by N fine grid to its coarse grid.
// Throughput: one fine sample per cycle unless a held output stalls the stencil stage;
// the line buffer read is registered at acceptance and the stencil sum finishes in
// the following cycle. A coarse point passes the s1 and output registers after its
// triggering sample. Reset (rst_n, async, active low) clears position, taps and valids
// and loads the config defaults; line buffers are not cleared and need no clearing pass.
module multigrid_half_weight_restrict
    import mghw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // fine_sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // coarse_value, coarse_row, coarse_col, zeros
    output logic                  m_axis_tlast    // last
);

    logic [SIZE_W-1:0]          fine_size_reg;
    logic signed [SAMPLE_W-1:0] boundary_reg;
    logic                       accept;
    pos_info_t                  info;
    logic signed [SAMPLE_W-1:0] mid;
    logic signed [SAMPLE_W-1:0] up;
    logic                       wr_en;
    logic [POS_W-1:0]           wr_addr;
    logic signed [SAMPLE_W-1:0] wr_one_back;
    logic signed [SAMPLE_W-1:0] wr_two_back;
    logic signed [SAMPLE_W-1:0] out_value;
    logic [IDX_W-1:0]           out_row;
    logic [IDX_W-1:0]           out_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fine_size_reg <= FINE_SIZE_RST;
            boundary_reg  <= BOUNDARY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FINE_SIZE: fine_size_reg <= cfg_wdata[SIZE_W-1:0];
                CFG_BOUNDARY:  boundary_reg  <= cfg_wdata[SAMPLE_W-1:0];
                default:       fine_size_reg <= fine_size_reg;
            endcase
        end
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    mghw_position u_position (
        .clk       (clk),
        .rst_n     (rst_n),
        .fine_size (fine_size_reg),
        .advance   (accept),
        .info      (info)
    );

    mghw_line_buffers u_line_buffers (
        .clk         (clk),
        .rd_en       (accept),
        .rd_addr     (info.col),
        .mid         (mid),
        .up          (up),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_one_back (wr_one_back),
        .wr_two_back (wr_two_back)
    );

    mghw_stencil u_stencil (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .sample         (s_axis_tdata),
        .info           (info),
        .ready          (s_axis_tready),
        .mid            (mid),
        .up             (up),
        .boundary_value (boundary_reg),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_one_back    (wr_one_back),
        .wr_two_back    (wr_two_back),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_value      (out_value),
        .out_row        (out_row),
        .out_col        (out_col),
        .out_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - OUT_FLD_W){1'b0}}, out_col, out_row, out_value};

endmodule
